// ===== hdl/csb_pkg.sv =====
// Shared types and constants for the color-keyed sprite blitter.
// Used by csb_front, csb_fifo, csb_back and color_keyed_sprite_blit.
// No dependencies.
package csb_pkg;

  // Configuration port widths
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 17;

  // Field widths
  localparam int PIXEL_W = 16;
  localparam int ADDR_W  = 18;
  localparam int POS_W   = 10;  // on-frame column or row, at most 1023
  localparam int COUNT_W = 9;   // sprite column / row counters

  // Largest value a 9-bit position counter reaches before it must wrap
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DEST_X            = 3'd0,
    REG_DEST_Y            = 3'd1,
    REG_SPRITE_WIDTH      = 3'd2,
    REG_SPRITE_HEIGHT     = 3'd3,
    REG_TRANSPARENT_COLOR = 3'd4,
    REG_PIXEL_MODE        = 3'd5
  } csb_reg_t;

  // One visible pixel, already clipped and keyed, waiting for its address
  typedef struct packed {
    logic [POS_W-1:0]   column;
    logic [POS_W-1:0]   row;
    logic [PIXEL_W-1:0] value;
  } csb_item_t;

endpackage

// ===== hdl/csb_front.sv =====
// Front end of the sprite blitter: configuration registers, sprite position
// counters, clipping and color-key test. Emits only visible pixels.
// Depends on csb_pkg.
module csb_front #(
  parameter int FRAME_WIDTH  = 512,
  parameter int FRAME_HEIGHT = 288
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [csb_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [csb_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                accept,
  input  logic [csb_pkg::PIXEL_W-1:0]         pixel_value,
  input  logic                                start_sprite,
  output logic                                item_valid,
  output csb_pkg::csb_item_t                  item
);
  import csb_pkg::*;

  localparam logic [11:0] FW = 12'(FRAME_WIDTH);
  localparam logic [11:0] FH = 12'(FRAME_HEIGHT);

  logic signed [9:0]  dest_x;
  logic signed [9:0]  dest_y;
  logic [9:0]         sprite_width;
  logic [8:0]         sprite_height;
  logic signed [16:0] transparent_color;
  logic               pixel_mode;

  logic [COUNT_W-1:0] column_count;
  logic [COUNT_W-1:0] row_count;
  logic [COUNT_W-1:0] column_count_next;
  logic [COUNT_W-1:0] row_count_next;

  logic [COUNT_W-1:0] col_eff;
  logic [COUNT_W-1:0] row_eff;
  logic [PIXEL_W-1:0] pix;
  logic [10:0]        fx;
  logic [10:0]        fy;
  logic               x_ok;
  logic               y_ok;
  logic               key_hit;
  logic [9:0]         col_inc;
  logic [9:0]         row_inc;

  // Configuration register file
  always_ff @(posedge clk) begin
    if (rst) begin
      dest_x            <= '0;
      dest_y            <= '0;
      sprite_width      <= 10'd1;
      sprite_height     <= 9'd1;
      transparent_color <= '1;
      pixel_mode        <= 1'b0;
    end else if (cfg_valid) begin
      unique case (csb_reg_t'(cfg_index))
        REG_DEST_X:            dest_x            <= cfg_data[9:0];
        REG_DEST_Y:            dest_y            <= cfg_data[9:0];
        REG_SPRITE_WIDTH:      sprite_width      <= cfg_data[9:0];
        REG_SPRITE_HEIGHT:     sprite_height     <= cfg_data[8:0];
        REG_TRANSPARENT_COLOR: transparent_color <= cfg_data;
        REG_PIXEL_MODE:        pixel_mode        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Start flag places this pixel at sprite origin
  assign col_eff = start_sprite ? '0 : column_count;
  assign row_eff = start_sprite ? '0 : row_count;

  // Pixel value, narrowed in eight-bit mode
  assign pix = pixel_mode ? pixel_value : {8'h00, pixel_value[7:0]};

  // Frame position and clip test
  assign fx   = {dest_x[9], dest_x} + {2'b00, col_eff};
  assign fy   = {dest_y[9], dest_y} + {2'b00, row_eff};
  assign x_ok = !fx[10] && ({2'b00, fx[9:0]} < FW);
  assign y_ok = !fy[10] && ({2'b00, fy[9:0]} < FH);

  // A negative key never matches
  assign key_hit = !transparent_color[16] && (transparent_color[15:0] == pix);

  assign item_valid  = x_ok && y_ok && !key_hit;
  assign item.column = fx[9:0];
  assign item.row    = fy[9:0];
  assign item.value  = pix;

  // Counter advance; zero size acts as one, width caps at 512
  assign col_inc = {1'b0, col_eff} + 10'd1;
  assign row_inc = {1'b0, row_eff} + 10'd1;

  always_comb begin
    if (col_inc >= sprite_width || col_eff == COUNT_MAX) begin
      column_count_next = '0;
      if (row_inc >= {1'b0, sprite_height} || row_eff == COUNT_MAX) begin
        row_count_next = '0;
      end else begin
        row_count_next = row_inc[COUNT_W-1:0];
      end
    end else begin
      column_count_next = col_inc[COUNT_W-1:0];
      row_count_next    = row_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

endmodule

// ===== hdl/csb_fifo.sv =====
// Short queue of visible pixels between front and back ends.
// Depends on csb_pkg.
module csb_fifo #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  csb_pkg::csb_item_t wr_data,
  output logic               full,
  input  logic               rd_en,
  output csb_pkg::csb_item_t rd_data,
  output logic               empty
);
  import csb_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  csb_item_t          mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_wr;
  logic               do_rd;

  assign full  = (count == FULL_COUNT);
  assign empty = (count == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  assign rd_data = mem[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/csb_back.sv =====
// Back end of the sprite blitter: forms the frame address and holds the
// write in an output register until it is popped.
// Depends on csb_pkg.
module csb_back #(
  parameter int FRAME_WIDTH = 512
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  csb_pkg::csb_item_t            q_data,
  output logic                          q_pop,
  input  logic                          pop,
  output logic                          empty,
  output logic [csb_pkg::ADDR_W-1:0]    frame_address,
  output logic [csb_pkg::PIXEL_W-1:0]   write_value
);
  import csb_pkg::*;

  localparam int PROD_W = 24;

  logic              out_valid;
  logic              load;
  logic [PROD_W-1:0] addr_full;

  // Row times frame width plus column, kept to the address width
  assign addr_full = PROD_W'(q_data.row) * PROD_W'(FRAME_WIDTH) + PROD_W'(q_data.column);

  assign load  = !q_empty && (!out_valid || pop);
  assign q_pop = load;
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_address <= addr_full[ADDR_W-1:0];
      write_value   <= q_data.value;
    end
  end

endmodule

// ===== hdl/color_keyed_sprite_blit.sv =====
// Color-keyed, clipped sprite blitter: top level.
// Depends on csb_pkg, csb_front, csb_fifo, csb_back.
//
//   channel   handshake          payload
//   -------   ----------------   ---------------------------------------
//   pixels    push / full        pixel_value, start_sprite
//   writes    pop / empty        frame_address, write_value
//   config    cfg_valid/ready    cfg_index, cfg_data
//
// One pixel is taken per cycle while full is low; a visible pixel's write
// passes through the queue, then the output register, before it appears
// on the result ports.
// full rises when the QUEUE_DEPTH-entry queue fills behind a stalled output.
// Reset clears the counters, the queue and the output; config regs take
// their defaults. Configuration is always ready.
module color_keyed_sprite_blit #(
  parameter int FRAME_WIDTH  = 512,
  parameter int FRAME_HEIGHT = 288,
  parameter int QUEUE_DEPTH  = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic [csb_pkg::PIXEL_W-1:0]         pixel_value,
  input  logic                                start_sprite,
  input  logic                                pop,
  output logic                                empty,
  output logic [csb_pkg::ADDR_W-1:0]          frame_address,
  output logic [csb_pkg::PIXEL_W-1:0]         write_value,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [csb_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [csb_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import csb_pkg::*;

  logic      accept;
  logic      item_valid;
  csb_item_t item;
  logic      q_full;
  logic      q_empty;
  logic      q_pop;
  csb_item_t q_data;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign accept    = push && !q_full;

  // Front: counters, clip, key
  csb_front #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .accept       (accept),
    .pixel_value  (pixel_value),
    .start_sprite (start_sprite),
    .item_valid   (item_valid),
    .item         (item)
  );

  // Queue between front and back
  csb_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept && item_valid),
    .wr_data (item),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  // Back: address and output register
  csb_back #(
    .FRAME_WIDTH (FRAME_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_data        (q_data),
    .q_pop         (q_pop),
    .pop           (pop),
    .empty         (empty),
    .frame_address (frame_address),
    .write_value   (write_value)
  );

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for color_keyed_sprite_blit: pixel items in, frame writes out.
// Depends on csb_pkg and the color_keyed_sprite_blit RTL. The expected writes come from
// a scoreboard class that tracks its own sprite counters and configuration.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import csb_pkg::*;

  localparam int FRAME_W       = 512;
  localparam int FRAME_H       = 288;
  localparam int ITEM_TARGET   = 850;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_LIMIT    = 2000;
  localparam int HOLD_CYCLES   = 60;

  // Expected frame writes plus a private copy of the blitter's state
  class blit_scoreboard;
    typedef struct {
      logic [ADDR_W-1:0]  addr;
      logic [PIXEL_W-1:0] value;
    } frame_write_t;

    frame_write_t pending_writes[$];
    int errors;

    logic signed [9:0]  dest_x;
    logic signed [9:0]  dest_y;
    logic [9:0]         sprite_width;
    logic [8:0]         sprite_height;
    logic signed [16:0] key_color;
    logic               wide_pixels;
    logic [COUNT_W-1:0] column_count;
    logic [COUNT_W-1:0] row_count;

    function new();
      errors        = 0;
      dest_x        = '0;
      dest_y        = '0;
      sprite_width  = 10'd1;
      sprite_height = 9'd1;
      key_color     = -17'sd1;
      wide_pixels   = 1'b0;
      column_count  = '0;
      row_count     = '0;
    endfunction

    function void write_reg(csb_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_DEST_X:            dest_x = data[9:0];
        REG_DEST_Y:            dest_y = data[9:0];
        REG_SPRITE_WIDTH:      sprite_width = data[9:0];
        REG_SPRITE_HEIGHT:     sprite_height = data[8:0];
        REG_TRANSPARENT_COLOR: key_color = data[16:0];
        REG_PIXEL_MODE:        wide_pixels = data[0];
        default: ;
      endcase
    endfunction

    // One accepted pixel: place it, clip it, key it, then advance the counters
    function void note_pixel(logic [PIXEL_W-1:0] value, logic start);
      frame_write_t entry;
      int fx, fy, pix;
      if (start) begin
        column_count = '0;
        row_count    = '0;
      end
      pix = wide_pixels ? int'(value) : int'(value[7:0]);
      fx  = int'(dest_x) + int'(column_count);
      fy  = int'(dest_y) + int'(row_count);
      if (fx >= 0 && fx < FRAME_W && fy >= 0 && fy < FRAME_H && pix != int'(key_color)) begin
        entry.addr  = ADDR_W'(fy * FRAME_W + fx);
        entry.value = PIXEL_W'(pix);
        pending_writes.push_back(entry);
      end
      // column wraps at the width or at the counter's top; rows wrap at the height
      if (int'(column_count) + 1 >= int'(sprite_width) || column_count == COUNT_MAX) begin
        column_count = '0;
        if (int'(row_count) + 1 >= int'(sprite_height) || row_count == COUNT_MAX) begin
          row_count = '0;
        end else begin
          row_count = row_count + 1'b1;
        end
      end else begin
        column_count = column_count + 1'b1;
      end
    endfunction

    function void check_write(logic [ADDR_W-1:0] addr, logic [PIXEL_W-1:0] value);
      frame_write_t exp_w;
      if (pending_writes.size() == 0) begin
        $display("%0t: unexpected write: expected none, actual addr %0d value 0x%04h",
                 $time, addr, value);
        errors++;
        return;
      end
      exp_w = pending_writes.pop_front();
      if (addr !== exp_w.addr) begin
        $display("%0t: frame_address mismatch: expected %0d actual %0d",
                 $time, exp_w.addr, addr);
        errors++;
      end
      if (value !== exp_w.value) begin
        $display("%0t: write_value mismatch: expected 0x%04h actual 0x%04h",
                 $time, exp_w.value, value);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   push = 1'b0;
  logic                   full;
  logic [PIXEL_W-1:0]     pixel_value = '0;
  logic                   start_sprite = 1'b0;
  logic                   pop = 1'b0;
  logic                   empty;
  logic [ADDR_W-1:0]      frame_address;
  logic [PIXEL_W-1:0]     write_value;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  blit_scoreboard sb = new();
  int             items_sent = 0;
  bit             tight = 1'b0;     // sender offers back to back
  bit             hold_req = 1'b0;  // asks the write side for one long stall
  logic [15:0]    palette [4];

  color_keyed_sprite_blit u_dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .pixel_value(pixel_value), .start_sprite(start_sprite),
    .pop(pop), .empty(empty), .frame_address(frame_address), .write_value(write_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Idle length: mostly none, some short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [15:0] pick_pixel();
    if ($urandom_range(0, 9) < 7) return palette[$urandom_range(0, 3)];
    return 16'($urandom);
  endfunction

  // Offer one pixel item and wait until it is taken
  task automatic send_pixel(input logic [PIXEL_W-1:0] value, input logic start);
    int gap;
    push         <= 1'b1;
    pixel_value  <= value;
    start_sprite <= start;
    do @(posedge clk); while (full);
    sb.note_pixel(value, start);
    items_sent++;
    gap = tight ? 0 : gap_len();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Register write; cfg_valid is left high for a following write
  task automatic write_reg(input csb_reg_t idx, input int val, input int width);
    logic [CFG_DATA_W-1:0] data, mask;
    mask = CFG_DATA_W'((64'd1 << width) - 1);
    data = CFG_DATA_W'($urandom);
    data = (data & ~mask) | (CFG_DATA_W'(val) & mask);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  // Wait for every expected write, then let pixels without a write clear the pipe
  task automatic settle_block();
    push <= 1'b0;
    while (sb.pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setup(input int dx, input int dy, input int w, input int h,
                             input int key, input bit mode);
    settle_block();
    write_reg(REG_DEST_X, dx, 10);
    write_reg(REG_DEST_Y, dy, 10);
    write_reg(REG_SPRITE_WIDTH, w, 10);
    write_reg(REG_SPRITE_HEIGHT, h, 9);
    write_reg(REG_TRANSPARENT_COLOR, key, 17);
    write_reg(REG_PIXEL_MODE, int'(mode), 1);
    cfg_valid <= 1'b0;
  endtask

  // Write side stalls alone for a long stretch while pixels keep coming
  task automatic run_fill_phase();
    apply_setup(0, 0, 16, 8, -1, 1'b1);
    hold_req = 1'b1;
    tight    = 1'b1;
    for (int i = 0; i < 40; i++) send_pixel(16'($urandom), i == 0);
    tight = 1'b0;
  endtask

  // Random setup, then a few sprites, mostly whole and well formed
  task automatic run_random_phase(input bit oversize);
    int  w, h, dx, dy, key, span, npix, sprites, r;
    bit  mode, lead_start;
    mode = 1'($urandom_range(0, 1));
    foreach (palette[i]) palette[i] = 16'($urandom);
    if (oversize) begin
      w  = $urandom_range(0, 1) ? 1023 : 600;
      h  = 2;
      dx = int'($urandom_range(0, 600)) - 300;
      dy = $urandom_range(0, 287);
    end else begin
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 6);
      if ($urandom_range(0, 9) == 0) w = 0;
      if ($urandom_range(0, 9) == 0) h = 0;
      case ($urandom_range(0, 3))
        0:       dx = int'($urandom_range(0, 1023)) - 512;
        1:       dx = 511 - int'($urandom_range(0, w + 2));
        2:       dx = -int'($urandom_range(0, w + 2));
        default: dx = $urandom_range(0, 500);
      endcase
      case ($urandom_range(0, 3))
        0:       dy = int'($urandom_range(0, 1023)) - 512;
        1:       dy = 287 - int'($urandom_range(0, h + 2));
        2:       dy = -int'($urandom_range(0, h + 2));
        default: dy = $urandom_range(0, 280);
      endcase
    end
    case ($urandom_range(0, 9))
      0, 1:       key = -1;
      2, 3, 4, 5: key = mode ? int'(palette[0]) : int'(palette[0][7:0]);
      6:          key = int'(palette[1]);
      7:          key = $urandom_range(0, 65535);
      8:          key = -int'($urandom_range(2, 65536));
      default:    key = 65535;
    endcase
    apply_setup(dx, dy, w, h, key, mode);

    tight   = ($urandom_range(0, 4) == 0);
    span    = (w == 0 ? 1 : (w > 512 ? 512 : w)) * (h == 0 ? 1 : h);
    sprites = oversize ? 1 : $urandom_range(1, 4);
    for (int s = 0; s < sprites; s++) begin
      r = $urandom_range(0, 19);
      if (oversize)    npix = $urandom_range(515, 540);
      else if (r == 0) npix = $urandom_range(1, span);
      else if (r == 1) npix = span + $urandom_range(1, 4);
      else             npix = span;
      lead_start = ($urandom_range(0, 5) != 0);
      for (int p = 0; p < npix; p++) begin
        send_pixel(pick_pixel(), p == 0 ? lead_start : ($urandom_range(0, 39) == 0));
      end
    end
    tight = 1'b0;
  endtask

  // Write side: check each accepted write, pop with random stalls and free runs
  initial begin
    int stall_left, hold_left, run_left;
    stall_left = 0;
    hold_left  = 0;
    run_left   = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (pop && !empty) sb.check_write(frame_address, write_value);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (run_left > 0) run_left--;
      else if ($urandom_range(0, 99) == 0) run_left = $urandom_range(30, 80);
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        stall_left = (run_left > 0) ? 0 : gap_len();
      end
    end
  end

  // Watchdog: too long without any handshake ends the run
  initial begin
    int idle;
    idle = 0;
    while (rst) @(posedge clk);
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) idle = 0;
      else idle++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Stimulus
  initial begin
    int phase;
    phase = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset setup: 1x1 sprite, no key, eight-bit pixels
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'h1234, 1'b0);

    // bottom-right corner clipping, sixteen-bit key match
    apply_setup(510, 286, 3, 3, 16'h00AB, 1'b1);
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'h00AB, 1'b0);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'h8001, 1'b0);
    send_pixel(16'h7FFE, 1'b0);
    send_pixel(16'h00AB, 1'b0);
    send_pixel(16'h5555, 1'b0);
    send_pixel(16'hAAAA, 1'b0);
    send_pixel(16'h0001, 1'b0);

    // zero width and height act as one; fully off the top-left
    apply_setup(-512, -512, 0, 0, 65535, 1'b0);
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'h0000, 1'b0);

    // key above the eight-bit range never matches; partial top-left clip
    apply_setup(-1, -1, 2, 2, 65535, 1'b0);
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'hFFFF, 1'b0);

    // widest sprite, full frame height, at the right edge; restart mid-row
    apply_setup(511, 0, 512, 288, 65535, 1'b1);
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'hFFFE, 1'b0);
    send_pixel(16'h1234, 1'b1);

    // eight-bit pixels: key zero matches on the low byte only
    apply_setup(0, 0, 1023, 1, 0, 1'b0);
    send_pixel(16'h0100, 1'b1);
    send_pixel(16'h0001, 1'b0);
    send_pixel(16'hFF00, 1'b0);

    // random phases
    while (items_sent < ITEM_TARGET) begin
      if (phase == 2) run_fill_phase();
      else run_random_phase(phase == 5);
      phase++;
    end

    settle_block();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/csb_pkg.sv
hdl/csb_front.sv
hdl/csb_fifo.sv
hdl/csb_back.sv
hdl/color_keyed_sprite_blit.sv
sim/tb_top.sv
